// ===== rtl/rrl_pkg.sv =====
package rrl_pkg;

    localparam int THREAD_SLOTS = 8;
    localparam int IDX_W        = $clog2(THREAD_SLOTS);
    localparam int CMD_W        = 2;
    localparam int ID_W         = 3;

    localparam logic [IDX_W-1:0] IDLE_ID = '0;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_ADV = 2'd2
    } rrl_cmd_t;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } rrl_mem_req_t;

    function automatic logic id_usable(input logic [ID_W-1:0] id);
        return (id != '0) && (32'(id) < THREAD_SLOTS);
    endfunction

endpackage

// ===== rtl/rrl_if.sv =====
interface rrl_cmd_if
    import rrl_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0] thread_id;

    modport source (output valid, output cmd, output thread_id, input ready);
    modport sink   (input valid, input cmd, input thread_id, output ready);
endinterface

interface rrl_res_if
    import rrl_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            status;
    logic [ID_W-1:0] current_thread;

    modport source (output valid, output status, output current_thread, input ready);
    modport sink   (input valid, input status, input current_thread, output ready);
endinterface

// ===== rtl/rrl_ram.sv =====
module rrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rrl_seq.sv =====
module rrl_seq
    import rrl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    rrl_cmd_if.sink          req,
    rrl_res_if.source        rsp,
    output rrl_mem_req_t     nl_req,
    output rrl_mem_req_t     pl_req,
    input  logic [IDX_W-1:0] nl_rdata,
    input  logic [IDX_W-1:0] pl_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADV,
        S_RD0,
        S_RD1,
        S_WR1,
        S_WR2
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    rrl_cmd_t         cmd_reg, cmd_next;
    logic [IDX_W-1:0] tid_reg, tid_next;
    logic [IDX_W-1:0] nt_reg, nt_next;
    logic [IDX_W-1:0] pt_reg, pt_next;
    logic [IDX_W-1:0] first_reg, first_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_cur_reg, out_cur_next;

    logic             accept;
    logic [IDX_W-1:0] req_idx;
    logic             is_first;
    logic             is_last;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign req_idx   = IDX_W'(req.thread_id);
    assign is_first  = (first_reg == tid_reg);
    assign is_last   = (last_reg == tid_reg);

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.current_thread = ID_W'(out_cur_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cmd_next        = cmd_reg;
        tid_next        = tid_reg;
        nt_next         = nt_reg;
        pt_next         = pt_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        cur_next        = cur_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_cur_next    = out_cur_reg;
        nl_req          = '0;
        pl_req          = '0;

        case (state_reg)
            S_CLEAR:
            begin
                nl_req.we    = 1'b1;
                nl_req.waddr = clr_cnt_reg;
                nl_req.wdata = IDLE_ID;
                pl_req.we    = 1'b1;
                pl_req.waddr = clr_cnt_reg;
                pl_req.wdata = IDLE_ID;
                if (clr_cnt_reg == IDX_W'(THREAD_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    tid_next = req_idx;
                    case (req.cmd)
                        CMD_ADV:
                        begin
                            cmd_next      = CMD_ADV;
                            nl_req.raddr  = cur_reg;
                            state_next    = S_ADV;
                        end
                        CMD_ENQ, CMD_DEQ:
                        begin
                            cmd_next = rrl_cmd_t'(req.cmd);
                            if (id_usable(req.thread_id))
                            begin
                                nl_req.raddr = req_idx;
                                pl_req.raddr = req_idx;
                                state_next   = S_RD0;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_FAIL;
                                out_cur_next    = cur_reg;
                            end
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_FAIL;
                            out_cur_next    = cur_reg;
                        end
                    endcase
                end
            end
            S_ADV:
            begin
                cur_next        = nl_rdata;
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_cur_next    = nl_rdata;
                state_next      = S_IDLE;
            end
            S_RD0:
            begin
                nt_next      = nl_rdata;
                pt_next      = pl_rdata;
                nl_req.raddr = IDLE_ID;
                pl_req.raddr = IDLE_ID;
                if ((cmd_reg == CMD_ENQ) == (nl_rdata != IDLE_ID))
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_FAIL;
                    out_cur_next    = cur_reg;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                first_next = nl_rdata;
                last_next  = pl_rdata;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                nl_req.we  = 1'b1;
                pl_req.we  = 1'b1;
                if (cmd_reg == CMD_ENQ)
                begin
                    nl_req.waddr = (first_reg == IDLE_ID) ? IDLE_ID : last_reg;
                    nl_req.wdata = tid_reg;
                    pl_req.waddr = tid_reg;
                    pl_req.wdata = last_reg;
                end
                else if (is_first && is_last)
                begin
                    nl_req.waddr = IDLE_ID;
                    nl_req.wdata = IDLE_ID;
                    pl_req.waddr = IDLE_ID;
                    pl_req.wdata = IDLE_ID;
                end
                else if (is_first)
                begin
                    nl_req.waddr = IDLE_ID;
                    nl_req.wdata = nt_reg;
                    pl_req.waddr = nt_reg;
                    pl_req.wdata = last_reg;
                end
                else if (is_last)
                begin
                    pl_req.waddr = IDLE_ID;
                    pl_req.wdata = pt_reg;
                    nl_req.waddr = pt_reg;
                    nl_req.wdata = first_reg;
                end
                else
                begin
                    nl_req.waddr = pt_reg;
                    nl_req.wdata = nt_reg;
                    pl_req.waddr = nt_reg;
                    pl_req.wdata = pt_reg;
                end
                state_next = S_WR2;
            end
            S_WR2:
            begin
                nl_req.we    = 1'b1;
                pl_req.we    = 1'b1;
                nl_req.waddr = tid_reg;
                if (cmd_reg == CMD_ENQ)
                begin
                    nl_req.wdata = ((first_reg == IDLE_ID) || (last_reg == IDLE_ID)) ?
                                   tid_reg : first_reg;
                    pl_req.waddr = IDLE_ID;
                    pl_req.wdata = tid_reg;
                end
                else
                begin
                    nl_req.wdata = IDLE_ID;
                    pl_req.waddr = tid_reg;
                    pl_req.wdata = IDLE_ID;
                end
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_cur_next    = cur_reg;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            cmd_reg        <= CMD_ENQ;
            tid_reg        <= '0;
            nt_reg         <= '0;
            pt_reg         <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            cur_reg        <= IDLE_ID;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_cur_reg    <= IDLE_ID;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            cmd_reg        <= cmd_next;
            tid_reg        <= tid_next;
            nt_reg         <= nt_next;
            pt_reg         <= pt_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            cur_reg        <= cur_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_cur_reg    <= out_cur_next;
        end
    end

endmodule

// ===== rtl/round_robin_ready_list.sv =====
// channel  dir  word                       handshake
// req      in   cmd, thread_id             valid / ready
// rsp      out  status, current_thread     valid / ready
//
// After reset a clearing pass zeroes both link memories; req.ready stays low meanwhile.
// One word in flight: advance reads the cursor's next link; enqueue and dequeue run the
// read-then-write steps S_RD0, S_RD1, S_WR1, S_WR2 on the single-port-pair link memories.
// A bad id or unused command answers at the accept edge; an already or not listed thread
// answers from S_RD0, once the link reads return.
// A new word is taken only once the result register is empty or drains in the same cycle.
module round_robin_ready_list
    import rrl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rrl_cmd_if.sink   req,
    rrl_res_if.source rsp
);

    rrl_mem_req_t     nl_req;
    rrl_mem_req_t     pl_req;
    logic [IDX_W-1:0] nl_rdata;
    logic [IDX_W-1:0] pl_rdata;

    rrl_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .nl_req   (nl_req),
        .pl_req   (pl_req),
        .nl_rdata (nl_rdata),
        .pl_rdata (pl_rdata)
    );

    rrl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (THREAD_SLOTS)
    ) u_next_ram (
        .clk   (clk),
        .we    (nl_req.we),
        .waddr (nl_req.waddr),
        .wdata (nl_req.wdata),
        .raddr (nl_req.raddr),
        .rdata (nl_rdata)
    );

    rrl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (THREAD_SLOTS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (pl_req.we),
        .waddr (pl_req.waddr),
        .wdata (pl_req.wdata),
        .raddr (pl_req.raddr),
        .rdata (pl_rdata)
    );

endmodule

// ===== rtl/rrl_chk.sv =====
module rrl_chk
    import rrl_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic [CMD_W-1:0] req_cmd,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_status,
    input logic [ID_W-1:0]  rsp_current_thread
);

    logic             req_acc;
    logic             rsp_acc;
    logic             pend_reg;
    logic [CMD_W-1:0] last_cmd_reg;
    logic [ID_W-1:0]  last_cur_reg;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            last_cmd_reg <= '0;
            last_cur_reg <= '0;
        end
        else
        begin
            if (req_acc)
            begin
                pend_reg     <= 1'b1;
                last_cmd_reg <= req_cmd;
            end
            else if (rsp_acc)
            begin
                pend_reg <= 1'b0;
            end
            if (rsp_acc)
            begin
                last_cur_reg <= rsp_current_thread;
            end
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc |-> pend_reg)
        else $error("result without an accepted word");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> !pend_reg || rsp_acc)
        else $error("second word taken before result delivered");

    a_cursor_kept: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc && (last_cmd_reg != CMD_W'(CMD_ADV)) |-> rsp_current_thread == last_cur_reg)
        else $error("cursor moved on enqueue or dequeue");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc && (last_cmd_reg == CMD_W'(CMD_ADV) || last_cmd_reg == CMD_UNUSED)
        |-> rsp_status == (last_cmd_reg != CMD_W'(CMD_ADV)))
        else $error("wrong status for advance or unused command");

endmodule

bind round_robin_ready_list rrl_chk u_rrl_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_cmd            (req.cmd),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_current_thread (rsp.current_thread)
);
